// File: src/cmse_pkg.sv
// Package for the cursor-move sequence encoder.
// Holds the item struct types and the ASCII codes of the command.
// No dependencies.
`default_nettype none

package cmse_pkg;

    // One input item: zero-based cursor position.
    typedef struct packed {
        logic [31:0] column;
        logic [31:0] row;
    } cmse_in_t;

    // One result item: a byte of the command and the end marker.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } cmse_out_t;

    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_FINAL    = 8'h48;
    localparam logic [7:0] DIGIT_BASE  = 8'd48;

endpackage

`default_nettype wire

// File: src/cursor_move_sequence_encoder_top.sv
// Top level of the cursor-move sequence encoder: sequencer and output register.
// Depends on cmse_pkg and on the shared converter cmse_bcd.
//
//  Channel  Ports                         Moves
//  input    s_valid, s_ready, s_item      column and row of one cursor position
//  result   m_valid, m_ready, m_item      one byte of ESC [ row ; column H, last on H
//
// An item is accepted, each coordinate is converted in turn in the shared
// shift-and-add-3 unit, and then the command goes out one byte per cycle while
// m_ready allows (6 to 24 bytes for the default COORD_BITS of 32).
// s_ready is high only between items; a stall on m_ready holds the sequencer.
// Reset is synchronous and clears the sequencer and the output valid.
`default_nettype none

module cursor_move_sequence_encoder_top
    import cmse_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire cmse_in_t s_item,
    output logic          m_valid,
    input  wire logic     m_ready,
    output cmse_out_t     m_item
);

    localparam int NDIG = (COORD_BITS * 30103) / 100000 + 1;
    localparam int DW   = $clog2(NDIG);

    typedef enum logic [3:0] {
        S_IDLE, S_ROW, S_COL, S_ESC, S_LBR, S_ROWD, S_SEMI, S_COLD, S_FIN
    } state_t;

    state_t                  state_reg, state_next;
    logic [COORD_BITS-1:0]   col_reg, col_next;
    logic [4*NDIG-1:0]       row_bcd_reg, row_bcd_next;
    logic [DW-1:0]           di_reg, di_next;
    logic                    out_valid_reg, out_valid_next;
    cmse_out_t               out_reg, out_next;

    logic [COORD_BITS-1:0]   row_raw, col_raw, row_one, col_one;
    logic                    cnv_start, cnv_done;
    logic [COORD_BITS-1:0]   cnv_value;
    logic [4*NDIG-1:0]       col_bcd;
    logic [DW-1:0]           lead_row, lead_col;
    logic [3:0]              row_dig, col_dig;
    logic                    load;

    // Make each coordinate one-based, holding it at the all-ones maximum.
    assign row_raw = s_item.row[COORD_BITS-1:0];
    assign col_raw = s_item.column[COORD_BITS-1:0];
    assign row_one = (row_raw == '1) ? row_raw : row_raw + COORD_BITS'(1);
    assign col_one = (col_raw == '1) ? col_raw : col_raw + COORD_BITS'(1);

    // The converter takes the row at accept and the column when the row is done.
    assign cnv_start = ((state_reg == S_IDLE) && s_valid)
                    || ((state_reg == S_ROW) && cnv_done);
    assign cnv_value = (state_reg == S_IDLE) ? row_one : col_reg;

    cmse_bcd #(
        .COORD_BITS (COORD_BITS)
    ) u_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cnv_start),
        .value   (cnv_value),
        .done    (cnv_done),
        .digits  (col_bcd)
    );

    // Position of the most significant nonzero digit of each coordinate.
    always_comb begin
        lead_row = '0;
        lead_col = '0;
        for (int i = 0; i < NDIG; i++) begin
            if (row_bcd_reg[4*i +: 4] != 4'd0) begin
                lead_row = DW'(i);
            end
            if (col_bcd[4*i +: 4] != 4'd0) begin
                lead_col = DW'(i);
            end
        end
    end

    assign row_dig = row_bcd_reg[4*di_reg +: 4];
    assign col_dig = col_bcd[4*di_reg +: 4];

    // The output register takes a new item when empty or being drained.
    assign load = !out_valid_reg || m_ready;

    // Sequencer: convert both coordinates, then send the command byte by byte.
    always_comb begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_bcd_next   = row_bcd_reg;
        di_next        = di_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    col_next   = col_one;
                    state_next = S_ROW;
                end
            end
            S_ROW: begin
                if (cnv_done) begin
                    row_bcd_next = col_bcd;
                    state_next   = S_COL;
                end
            end
            S_COL: begin
                if (cnv_done) begin
                    state_next = S_ESC;
                end
            end
            S_ESC: begin
                if (load) begin
                    out_valid_next = 1'b1;
                    out_next       = '{out_byte: CH_ESC, last: 1'b0};
                    state_next     = S_LBR;
                end
            end
            S_LBR: begin
                if (load) begin
                    out_valid_next = 1'b1;
                    out_next       = '{out_byte: CH_LBRACKET, last: 1'b0};
                    di_next        = lead_row;
                    state_next     = S_ROWD;
                end
            end
            S_ROWD: begin
                if (load) begin
                    out_valid_next = 1'b1;
                    out_next       = '{out_byte: DIGIT_BASE + {4'd0, row_dig}, last: 1'b0};
                    di_next        = di_reg - DW'(1);
                    if (di_reg == '0) begin
                        state_next = S_SEMI;
                    end
                end
            end
            S_SEMI: begin
                if (load) begin
                    out_valid_next = 1'b1;
                    out_next       = '{out_byte: CH_SEMI, last: 1'b0};
                    di_next        = lead_col;
                    state_next     = S_COLD;
                end
            end
            S_COLD: begin
                if (load) begin
                    out_valid_next = 1'b1;
                    out_next       = '{out_byte: DIGIT_BASE + {4'd0, col_dig}, last: 1'b0};
                    di_next        = di_reg - DW'(1);
                    if (di_reg == '0) begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (load) begin
                    out_valid_next = 1'b1;
                    out_next       = '{out_byte: CH_FINAL, last: 1'b1};
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        col_reg     <= col_next;
        row_bcd_reg <= row_bcd_next;
        di_reg      <= di_next;
        out_reg     <= out_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

`default_nettype wire

// File: src/cmse_bcd.sv
// Shared binary-to-decimal converter of the cursor-move sequence encoder.
// Shift-and-add-3 over one input bit per cycle. Depends on nothing.
`default_nettype none

module cmse_bcd #(
    parameter int COORD_BITS = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [COORD_BITS-1:0]         value,
    output logic                               done,
    output logic [4*((COORD_BITS*30103)/100000+1)-1:0] digits
);

    localparam int NDIG = (COORD_BITS * 30103) / 100000 + 1;
    localparam int CW   = $clog2(COORD_BITS + 1);

    logic [COORD_BITS-1:0] shift_reg, shift_next;
    logic [4*NDIG-1:0]     bcd_reg, bcd_next;
    logic [4*NDIG-1:0]     adj;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    // Each decimal digit of five or more is raised by three before the shift.
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // Step control: load on start, then shift one bit per cycle.
    always_comb begin
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            shift_next = value;
            bcd_next   = '0;
            cnt_next   = CW'(COORD_BITS);
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            bcd_next   = {adj[4*NDIG-2:0], shift_reg[COORD_BITS-1]};
            shift_next = {shift_reg[COORD_BITS-2:0], 1'b0};
            cnt_next   = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
    end

    assign done   = done_reg;
    assign digits = bcd_reg;

endmodule

`default_nettype wire

// File: src/cmse_checker.sv
// Port checker for the cursor-move sequence encoder, bound to the top level.
// Depends on cmse_pkg and on cursor_move_sequence_encoder_top.
`default_nettype none

module cmse_port_checker
    import cmse_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire cmse_in_t  s_item,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire cmse_out_t m_item
);

    // A waiting input item keeps its position until it is taken.
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_item))
        else $error("input item changed while waiting");

    // A stalled result item holds its byte and marker.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item changed while stalled");

    // The block takes no second item right after accepting one.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted twice in a row");

    // The end marker comes only with the closing byte.
    a_last_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.last |-> m_item.out_byte == CH_FINAL)
        else $error("end marker on a byte other than the closing one");

    // While open for input, at most the closing byte of the last item waits.
    a_idle_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && m_valid |-> m_item.last)
        else $error("input open while a command is still being sent");

endmodule

bind cursor_move_sequence_encoder_top cmse_port_checker u_cmse_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire

// File: tb/cmse_checker.sv
`timescale 1ns / 1ps
// Checker for the cursor-move sequence encoder: watches both channels,
// predicts the command bytes of each accepted position and compares them.
// Depends on cmse_pkg for the item types and the ASCII codes.

module cmse_checker
    import cmse_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  cmse_in_t  s_item,
    input  logic      m_valid,
    input  logic      m_ready,
    input  cmse_out_t m_item,
    output int        fail_count,
    output int        expected_count
);

    localparam int          RADIX      = 10;
    localparam logic [63:0] COORD_MASK = (64'd1 << COORD_BITS) - 64'd1;

    // Command bytes still owed by the block, newest at the front, oldest at the back.
    cmse_out_t cmd_bytes_q[$];

    initial begin
        fail_count     = 0;
        expected_count = 0;
    end

    // One line per mismatch, and the count goes up.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] ERROR %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    // Masks a raw coordinate to COORD_BITS and makes it one-based, saturating at all-ones.
    function automatic logic [63:0] one_based_coord(input logic [31:0] raw);
        logic [63:0] v;
        v = {32'd0, raw} & COORD_MASK;
        if (v != COORD_MASK) begin
            v = v + 64'd1;
        end
        return v;
    endfunction

    function automatic void push_cmd_byte(input logic [7:0] b, input logic fin);
        cmse_out_t r;
        r.out_byte = b;
        r.last     = fin;
        cmd_bytes_q.push_front(r);
    endfunction

    // Decimal digits, most significant first, without leading zeros.
    function automatic void push_decimal(input logic [63:0] val);
        logic [7:0]  digits[$];
        logic [63:0] v;
        v = val;
        while (v != 64'd0) begin
            digits.push_front(DIGIT_BASE + 8'(v % RADIX));
            v = v / RADIX;
        end
        foreach (digits[i]) begin
            push_cmd_byte(digits[i], 1'b0);
        end
    endfunction

    // Full command for one position: ESC [ row ; column H.
    function automatic void predict_cursor_cmd(input cmse_in_t pos);
        push_cmd_byte(CH_ESC, 1'b0);
        push_cmd_byte(CH_LBRACKET, 1'b0);
        push_decimal(one_based_coord(pos.row));
        push_cmd_byte(CH_SEMI, 1'b0);
        push_decimal(one_based_coord(pos.column));
        push_cmd_byte(CH_FINAL, 1'b1);
    endfunction

    // Sample both channels on the rising edge.
    always @(posedge aclk) begin
        cmse_out_t want;
        if (!aresetn) begin
            cmd_bytes_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                predict_cursor_cmd(s_item);
            end
            if (m_valid && m_ready) begin
                if (cmd_bytes_q.size() == 0) begin
                    report_mismatch("byte with no command pending", m_item.out_byte, 0);
                end else begin
                    want = cmd_bytes_q.pop_back();
                    if (m_item.out_byte !== want.out_byte) begin
                        report_mismatch("out_byte", m_item.out_byte, want.out_byte);
                    end
                    if (m_item.last !== want.last) begin
                        report_mismatch("last", m_item.last, want.last);
                    end
                end
            end
        end
        expected_count <= cmd_bytes_q.size();
    end

endmodule

// File: tb/tb_cursor_move_sequence_encoder_top.sv
`timescale 1ns / 1ps
// Testbench top for the cursor-move sequence encoder: clock, reset, position
// stimulus, result back-pressure and the verdict. Depends on cmse_pkg,
// cursor_move_sequence_encoder_top and cmse_checker.

module tb_cursor_move_sequence_encoder_top;
    import cmse_pkg::*;

    localparam int COORD_BITS   = 32;
    localparam int MAX_IDLE     = 18;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 130;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int SETTLE       = 100;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    cmse_in_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    cmse_out_t m_item;

    int fail_count;
    int expected_count;

    // Shared knobs: idling on or off, and requests for a long receiver hold-off.
    bit idle_on       = 1'b1;
    int hold_requests = 0;

    always #5 aclk = ~aclk;

    cursor_move_sequence_encoder_top #(
        .COORD_BITS(COORD_BITS)
    ) u_top (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

    cmse_checker #(
        .COORD_BITS(COORD_BITS)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item        (s_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item        (m_item),
        .fail_count    (fail_count),
        .expected_count(expected_count)
    );

    // Offers one position and returns at the edge where it is accepted.
    // With wait_drain set, the sender first pauses until every byte has come out.
    task automatic send_position(input logic [31:0] col, input logic [31:0] row,
                                 input bit wait_drain);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        @(negedge aclk);
        if (gap > 0 || wait_drain) begin
            s_valid <= 1'b0;
        end
        if (wait_drain) begin
            @(negedge aclk);
            while (expected_count != 0) @(negedge aclk);
        end
        repeat (gap) @(negedge aclk);
        s_item.column <= col;
        s_item.row    <= row;
        s_valid       <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Mix of small values, digit-count boundaries, values near the top and full range.
    function automatic logic [31:0] rand_coord();
        logic [31:0] pow10;
        int          k;
        pow10 = 32'd1;
        k     = $urandom_range(1, 9);
        repeat (k) pow10 = pow10 * 32'd10;
        case ($urandom_range(0, 5))
            0: begin
                return $urandom_range(0, 99);
            end
            1: begin
                return pow10 - $urandom_range(0, 2);
            end
            2: begin
                return 32'hFFFF_FFFF - $urandom_range(0, 3);
            end
            default: begin
                return $urandom();
            end
        endcase
    endfunction

    // Result side: random stalls per byte, plus the long hold-off when asked.
    initial begin
        int stall;
        int holds_done;
        holds_done = 0;
        forever begin
            @(negedge aclk);
            stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (holds_done != hold_requests) begin
                stall = LONG_HOLD;
                holds_done++;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Run limit.
    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        int waited;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: shortest and longest commands, saturation and digit boundaries.
        send_position(32'd0, 32'd0, 1'b0);
        send_position(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_position(32'hFFFF_FFFE, 32'hFFFF_FFFE, 1'b0);
        send_position(32'hFFFF_FFFF, 32'd0, 1'b0);
        send_position(32'd0, 32'hFFFF_FFFF, 1'b0);
        send_position(32'd8, 32'd9, 1'b0);
        send_position(32'd98, 32'd99, 1'b0);
        send_position(32'd999_999_999, 32'd999_999_998, 1'b0);
        send_position(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_position(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        send_position(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        send_position(32'd4_294_967_294, 32'd1, 1'b0);
        send_position(32'd12345, 32'd67890, 1'b0);

        // Random positions with phases of no idling, a long hold-off and a drain pause.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 20) begin
                idle_on = 1'b0;
            end
            if (i == 40) begin
                hold_requests++;
            end
            if (i == 55) begin
                idle_on = 1'b1;
            end
            send_position(rand_coord(), rand_coord(), i == 90);
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        // Let the last bytes drain, then allow some settling time.
        waited = 0;
        while (expected_count != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (SETTLE) @(negedge aclk);

        if (fail_count == 0 && expected_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/cmse_pkg.sv
src/cmse_bcd.sv
src/cursor_move_sequence_encoder_top.sv
src/cmse_checker.sv
tb/cmse_checker.sv
tb/tb_cursor_move_sequence_encoder_top.sv
